@@ design/kmds_pkg.sv @@
// kmds_pkg: shared types, sizes and helpers for the key matrix debounce scanner
// used by kmds_hist_mem, kmds_ctrl and key_matrix_debounce_scanner
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package kmds_pkg;

  // matrix geometry
  localparam int ROWS    = 7;
  localparam int SAMPLES = 8;

  // field widths
  localparam int ROW_W = 3;
  localparam int PIN_W = 12;
  localparam int COL_W = 12;
  localparam int CNT_W = 7;
  localparam int POP_W = $clog2(COL_W + 1);

  // index widths
  localparam int ROW_IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SLOT_W    = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic [ROW_W-1:0] row_index;
    logic [PIN_W-1:0] pin_levels;
  } sample_t;

  typedef struct packed {
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] debounced_cols;
    logic             pass_done;
    logic [CNT_W-1:0] pressed_total;
  } result_t;

  // history store access from the sequencer
  typedef struct packed {
    logic                 wr_en;
    logic [ROW_IDX_W-1:0] wr_row;
    logic [SLOT_W-1:0]    wr_slot;
    logic [COL_W-1:0]     wr_data;
    logic [ROW_IDX_W-1:0] rd_row;
    logic [SLOT_W-1:0]    rd_slot;
  } mem_req_t;

  function automatic logic [POP_W-1:0] pop_count(input logic [COL_W-1:0] v);
    logic [POP_W-1:0] n;
    n = '0;
    for (int i = 0; i < COL_W; i++) begin
      n = n + POP_W'(v[i]);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

@@ design/kmds_hist_mem.sv @@
// kmds_hist_mem: per-row sample history store with registered read
// entries never written since reset read as zero (valid bit per entry)
// depends on kmds_pkg
`timescale 1ns / 1ps
`default_nettype none
module kmds_hist_mem (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire kmds_pkg::mem_req_t      req,
  output logic [kmds_pkg::COL_W-1:0]   rd_data
);

  logic [kmds_pkg::COL_W-1:0] mem [kmds_pkg::ROWS][kmds_pkg::SAMPLES];
  logic [kmds_pkg::SAMPLES-1:0] vbits [kmds_pkg::ROWS];
  logic [kmds_pkg::COL_W-1:0] rd_q;
  logic                       rd_vld;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_row][req.wr_slot] <= req.wr_data;
    end
    rd_q <= mem[req.rd_row][req.rd_slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < kmds_pkg::ROWS; r++) begin
        vbits[r] <= '0;
      end
      rd_vld <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vbits[req.wr_row][req.wr_slot] <= 1'b1;
      end
      rd_vld <= vbits[req.rd_row][req.rd_slot];
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule
`default_nettype wire

@@ design/kmds_ctrl.sv @@
// kmds_ctrl: sequencer that stores a row sample, sweeps its history through
// one shared and-accumulator and forms the debounced result and running count
// depends on kmds_pkg and kmds_hist_mem
`timescale 1ns / 1ps
`default_nettype none
module kmds_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [kmds_pkg::ROW_W-1:0] start_row,
  input  wire logic [kmds_pkg::COL_W-1:0] start_cols,
  output logic                           busy,
  output logic                           res_valid,
  input  wire logic                      res_take,
  output kmds_pkg::result_t              res
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SWEEP  = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t                         state, state_next;
  logic [kmds_pkg::ROW_W-1:0]     row;
  logic                           in_range;
  logic [kmds_pkg::SLOT_W-1:0]    idx;
  logic [kmds_pkg::SLOT_W-1:0]    ring_slot;
  logic [kmds_pkg::CNT_W-1:0]     running_count;
  logic [kmds_pkg::COL_W-1:0]     acc;
  logic                           rd_live;
  logic [kmds_pkg::COL_W-1:0]     rd_data;
  kmds_pkg::mem_req_t             req;
  logic                           start_in_range;
  logic [kmds_pkg::CNT_W:0]       sum;
  logic [kmds_pkg::CNT_W-1:0]     total;
  logic                           last_row;

  kmds_hist_mem u_hist (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rd_data (rd_data)
  );

  assign start_in_range = (32'(start_row) < kmds_pkg::ROWS);
  assign last_row       = (32'(row) == kmds_pkg::ROWS - 1);

  always_comb begin
    req.wr_en   = start && start_in_range;
    req.wr_row  = kmds_pkg::ROW_IDX_W'(start_row);
    req.wr_slot = ring_slot;
    req.wr_data = start_cols;
    req.rd_row  = kmds_pkg::ROW_IDX_W'(row);
    req.rd_slot = idx;
  end

  // saturating running total
  assign sum   = {1'b0, running_count} + (kmds_pkg::CNT_W + 1)'(kmds_pkg::pop_count(acc));
  assign total = !in_range ? running_count :
                 (sum[kmds_pkg::CNT_W] ? kmds_pkg::COUNT_MAX : sum[kmds_pkg::CNT_W-1:0]);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = start_in_range ? ST_SWEEP : ST_FINISH;
        end
      end
      ST_SWEEP: begin
        if (32'(idx) == kmds_pkg::SAMPLES - 1) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_FINISH;
      ST_FINISH: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      ring_slot     <= '0;
      running_count <= '0;
      rd_live       <= 1'b0;
      idx           <= '0;
    end else begin
      state   <= state_next;
      rd_live <= (state == ST_SWEEP);
      if (state == ST_SWEEP) begin
        idx <= idx + kmds_pkg::SLOT_W'(1);
      end else begin
        idx <= '0;
      end
      if (state == ST_FINISH && res_take && in_range) begin
        if (last_row) begin
          running_count <= '0;
          ring_slot <= (32'(ring_slot) == kmds_pkg::SAMPLES - 1) ? '0
                       : ring_slot + kmds_pkg::SLOT_W'(1);
        end else begin
          running_count <= total;
        end
      end
    end
  end

  // item payload and the shared and-accumulator
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      row      <= start_row;
      in_range <= start_in_range;
      acc      <= start_in_range ? '1 : '0;
    end else if (rd_live) begin
      acc <= acc & rd_data;
    end
  end

  assign busy      = (state != ST_IDLE);
  assign res_valid = (state == ST_FINISH);

  always_comb begin
    res.out_row        = row;
    res.debounced_cols = acc;
    res.pass_done      = in_range && last_row;
    res.pressed_total  = total;
  end

endmodule
`default_nettype wire

@@ design/key_matrix_debounce_scanner.sv @@
// key_matrix_debounce_scanner: top level of the keyboard row scanner with
// shift-history debounce; pin mapping, config register and result register
// depends on kmds_pkg and kmds_ctrl
`timescale 1ns / 1ps
`default_nettype none
//
//  channel   signals                          payload
//  -------   -------------------------------  -----------------------------
//  sample    sample_valid / sample_ready      row_index, pin_levels
//  result    result_valid / result_ready      out_row, debounced_cols,
//                                             pass_done, pressed_total
//  cfg       cfg_valid / cfg_ready            alt_column_order (cfg_data)
//
//  an in-range request sweeps the history of the row from accept to result load,
//  one entry per cycle through the single and-accumulator, paced by the one read
//  port of the history store, then drains the last read; an out-of-range row
//  skips the sweep; sample_ready is low while a row is in work
//  a finished result waits in the result register, so the next request can be
//  accepted while the previous result is still stalled
//  reset is synchronous; history entries carry valid bits and read as zero
//  until written, so no clearing pass is needed
//
module key_matrix_debounce_scanner (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              sample_valid,
  output logic                   sample_ready,
  input  wire kmds_pkg::sample_t sample,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output kmds_pkg::result_t      result,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_data
);

  logic                         alt_column_order;
  logic [kmds_pkg::PIN_W-1:0]   pressed;
  logic [kmds_pkg::COL_W-1:0]   cols;
  logic                         busy;
  logic                         start;
  logic                         res_valid;
  logic                         res_take;
  kmds_pkg::result_t            res;

  // config register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      alt_column_order <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      alt_column_order <= cfg_data;
    end
  end

  // pins are active low; port B and F4 keep their place, F5..F7 depend on board revision
  assign pressed = ~sample.pin_levels;

  always_comb begin
    cols[8:0] = pressed[8:0];
    if (alt_column_order) begin
      cols[9]  = pressed[9];
      cols[10] = pressed[10];
      cols[11] = pressed[11];
    end else begin
      cols[9]  = pressed[11];
      cols[10] = pressed[9];
      cols[11] = pressed[10];
    end
  end

  assign sample_ready = !busy;
  assign start        = sample_valid && sample_ready;

  kmds_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .start_row  (sample.row_index),
    .start_cols (cols),
    .busy       (busy),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res)
  );

  // result register: load when empty or being drained this cycle
  assign res_take = res_valid && (!result_valid || result_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_take) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      result <= res;
    end
  end

  // end of pass is only flagged for the final row
  a_pass_row: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.pass_done |-> 32'(result.out_row) == kmds_pkg::ROWS - 1)
    else $error("pass_done on a row other than the final one");

  // out-of-range rows report no keys
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && 32'(result.out_row) >= kmds_pkg::ROWS |-> result.debounced_cols == '0)
    else $error("keys reported for an out-of-range row");

  // a request is never followed by another in the next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready)
    else $error("sequencer took a second request while busy");

  // the running total covers at least the keys of the reported row
  a_total_covers_row: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> kmds_pkg::CNT_W'(kmds_pkg::pop_count(result.debounced_cols))
                     <= result.pressed_total)
    else $error("pressed total below the keys of this row");

endmodule
`default_nettype wire

@@ verif/key_matrix_debounce_scanner_tb.sv @@
// key_matrix_debounce_scanner_tb: self-checking bench for the keyboard row scanner
// drives sampled rows and column-order writes, predicts every debounced row report
// depends on kmds_pkg and key_matrix_debounce_scanner
`timescale 1ns / 1ps
module key_matrix_debounce_scanner_tb;
  import kmds_pkg::*;

  // port f pin positions inside pin_levels
  localparam int F5_BIT = 9;
  localparam int F6_BIT = 10;
  localparam int F7_BIT = 11;

  localparam int IDLE_LIMIT    = 1000;              // cycles with no handshake at all
  localparam int SETTLE_CYCLES = 2 * (SAMPLES + 2); // settle time after the last report
  localparam int RANDOM_ITEMS  = 1030;
  localparam int HALF_PHASE    = RANDOM_ITEMS / 6;  // three idling modes, two orders each

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    sample_valid = 1'b0;
  logic    sample_ready;
  sample_t sample       = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;
  logic    cfg_valid    = 1'b0;
  logic    cfg_ready;
  logic    cfg_data     = 1'b0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatches    = 0;
  int unsigned quiet_cycles  = 0;

  // shadow of the scanner state
  logic [COL_W-1:0] key_history [ROWS][SAMPLES];
  int unsigned      ring_pos;
  int unsigned      pass_count;
  logic             col_order_alt;
  result_t          row_reports [$];

  // raw pressed-pin masks that the random part holds down, one per row
  logic [PIN_W-1:0] held_keys [ROWS];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  key_matrix_debounce_scanner dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  // active-low pins to pressed columns; only columns nine to eleven move with the order bit
  function automatic logic [COL_W-1:0] map_pins(input logic [PIN_W-1:0] pins,
                                                input logic alt);
    logic [COL_W-1:0] down;
    logic [COL_W-1:0] cols;
    down = ~pins;
    cols = down;
    if (!alt) begin
      cols[9]  = down[F7_BIT];
      cols[10] = down[F5_BIT];
      cols[11] = down[F6_BIT];
    end
    return cols;
  endfunction

  function automatic int unsigned count_keys(input logic [COL_W-1:0] cols);
    int unsigned n;
    n = 0;
    for (int i = 0; i < COL_W; i++) begin
      n += 32'(cols[i]);
    end
    return n;
  endfunction

  // one row request: store the sample, and the history and gives the debounced state
  task automatic debounce_row(input sample_t s, output result_t r);
    logic [COL_W-1:0] acc;
    int unsigned      total;
    r.out_row        = s.row_index;
    r.debounced_cols = '0;
    r.pass_done      = 1'b0;
    r.pressed_total  = pass_count[CNT_W-1:0];
    // a row past the last one leaves everything untouched
    if (s.row_index < ROWS) begin
      key_history[s.row_index][ring_pos] = map_pins(s.pin_levels, col_order_alt);
      acc = '1;
      for (int k = 0; k < SAMPLES; k++) begin
        acc &= key_history[s.row_index][k];
      end
      total = pass_count + count_keys(acc);
      if (total > COUNT_MAX) begin
        total = COUNT_MAX;
      end
      r.debounced_cols = acc;
      r.pressed_total  = total[CNT_W-1:0];
      // the final row closes the pass and moves to the next ring slot
      if (s.row_index == ROWS - 1) begin
        r.pass_done = 1'b1;
        pass_count  = 0;
        ring_pos    = (ring_pos + 1) % SAMPLES;
      end else begin
        pass_count = total;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t ns mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  // prediction at each accepted request, checking at each accepted result
  always @(posedge clk) begin
    result_t want;
    result_t fresh;
    if (rst) begin
      foreach (key_history[r, k]) begin
        key_history[r][k] = '0;
      end
      ring_pos      = 0;
      pass_count    = 0;
      col_order_alt = 1'b0;
      row_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        col_order_alt = cfg_data;
      end
      if (result_valid && result_ready) begin
        if (row_reports.size() == 0) begin
          report_mismatch("result with no request waiting", result, 0);
        end else begin
          want = row_reports.pop_front();
          if (result.out_row != want.out_row) begin
            report_mismatch("out_row", result.out_row, want.out_row);
          end
          if (result.debounced_cols != want.debounced_cols) begin
            report_mismatch("debounced_cols", result.debounced_cols, want.debounced_cols);
          end
          if (result.pass_done != want.pass_done) begin
            report_mismatch("pass_done", result.pass_done, want.pass_done);
          end
          if (result.pressed_total != want.pressed_total) begin
            report_mismatch("pressed_total", result.pressed_total, want.pressed_total);
          end
        end
      end
      if (sample_valid && sample_ready) begin
        debounce_row(sample, fresh);
        row_reports.push_back(fresh);
      end
    end
  end

  // watchdog: a long stretch with no handshake on any channel ends the run
  always @(posedge clk) begin
    if (rst || (sample_valid && sample_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver stalls at random, decided at every falling edge
  always @(negedge clk) begin
    result_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // one row request; valid stays high into the next call unless a gap is drawn
  task automatic send_sample(input logic [ROW_W-1:0] row, input logic [PIN_W-1:0] pins);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= '{row_index: row, pin_levels: pins};
    do @(posedge clk); while (!sample_ready);
    @(negedge clk);
  endtask

  // drop valid, let every report come back, then give the block time to go quiet
  task automatic wait_for_reports();
    sample_valid <= 1'b0;
    while (row_reports.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // column order write; only called with the sample channel drained
  task automatic set_column_order(input logic alt);
    cfg_valid <= 1'b1;
    cfg_data  <= alt;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // held keys seen through the pins, now and then with one bouncing contact
  function automatic logic [PIN_W-1:0] held_pins(input int unsigned row);
    logic [PIN_W-1:0] p;
    p = ~held_keys[row];
    if ($urandom_range(9) == 0) begin
      p[$urandom_range(PIN_W - 1)] ^= 1'b1;
    end
    return p;
  endfunction

  // fresh state: a released row, a fully pressed row with no history yet, and a row past the last one
  task automatic test_idle_matrix();
    send_sample(ROW_W'(0), '1);
    send_sample(ROW_W'(ROWS - 2), '0);
    send_sample(3'd7, '0);
    wait_for_reports();
  endtask

  // the last row held for a full ring of passes, then one key let go
  task automatic test_debounce_fill();
    repeat (SAMPLES) send_sample(ROW_W'(ROWS - 1), '0);
    // only pin b0 released: that column drops at once
    send_sample(ROW_W'(ROWS - 1), 12'h001);
    wait_for_reports();
  endtask

  // with the last row's history still mostly pressed, single pins show the column map
  task automatic test_column_order();
    set_column_order(1'b1);
    send_sample(ROW_W'(ROWS - 1), ~(PIN_W'(1) << F5_BIT));
    wait_for_reports();
    set_column_order(1'b0);
    send_sample(ROW_W'(ROWS - 1), ~(PIN_W'(1) << F7_BIT));
    send_sample(ROW_W'(ROWS - 1), ~(PIN_W'(1) << F5_BIT));
    wait_for_reports();
  endtask

  // rows out of order, with an out-of-range row in the middle of the pass
  task automatic test_row_order();
    send_sample(3'd3, '0);
    send_sample(3'd1, '0);
    send_sample(3'd7, '1);
    send_sample(3'd2, '0);
    send_sample(ROW_W'(ROWS - 1), '1);
    wait_for_reports();
  endtask

  // mostly whole passes over slowly changing held keys, plus broken passes,
  // repeated rows and raw noise
  task automatic run_random_keys(input int unsigned budget);
    int unsigned      sent;
    int unsigned      kind;
    int unsigned      first;
    int unsigned      last;
    int unsigned      reps;
    logic [ROW_W-1:0] r;
    sent = 0;
    foreach (held_keys[i]) begin
      held_keys[i] = '1;
    end
    while (sent < budget) begin
      kind = $urandom_range(99);
      if (kind < 60) begin
        for (int i = 0; i < ROWS; i++) begin
          send_sample(ROW_W'(i), held_pins(i));
        end
        sent += ROWS;
      end else if (kind < 72) begin
        // a pass that starts late, skips rows or never reaches the final row
        first = $urandom_range(ROWS - 1);
        last  = $urandom_range(ROWS - 1, first);
        for (int i = first; i <= last; i++) begin
          if ($urandom_range(3) != 0) begin
            send_sample(ROW_W'(i), held_pins(i));
            sent++;
          end
        end
      end else if (kind < 86) begin
        // one row over and over: with keys held this pushes the total into saturation
        r    = ROW_W'($urandom_range(ROWS - 2));
        reps = $urandom_range(14, 2);
        repeat (reps) send_sample(r, held_pins(32'(r)));
        sent += reps;
      end else begin
        reps = $urandom_range(4, 1);
        repeat (reps) send_sample(ROW_W'($urandom_range(7)), PIN_W'($urandom_range(4095)));
        sent += reps;
      end
      // let the held keys drift
      kind = $urandom_range(99);
      if (kind < 3) begin
        foreach (held_keys[i]) begin
          held_keys[i] = '1;
        end
      end else if (kind < 5) begin
        foreach (held_keys[i]) begin
          held_keys[i] = '0;
        end
      end else if (kind < 12) begin
        held_keys[$urandom_range(ROWS - 1)] = PIN_W'($urandom_range(4095));
      end else if (kind < 25) begin
        r = ROW_W'($urandom_range(ROWS - 1));
        held_keys[r][$urandom_range(PIN_W - 1)] ^= 1'b1;
      end
    end
    wait_for_reports();
  endtask

  initial begin
    // reset held from time zero, released on a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    set_idling(14, 67);
    test_idle_matrix();
    test_debounce_fill();
    test_column_order();
    test_row_order();

    // each idling mode runs under both column orders
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          set_idling(14, 67);
        end
        1: begin
          set_idling(67, 14);
        end
        default: begin
          set_idling(0, 0);
        end
      endcase
      set_column_order(1'b1);
      run_random_keys(HALF_PHASE);
      set_column_order(1'b0);
      run_random_keys(HALF_PHASE);
    end

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
